// ===== sv/mmcs_pkg.sv =====
// Package for the min/max contrast stretch block: word types, lane control
// struct, register indexes and widths. No dependencies.
`default_nettype none

package mmcs_pkg;

  localparam int CHAN_W           = 8;
  localparam int LEVEL_W          = 8;
  localparam int MAX_LANES        = 3;
  localparam int PIXEL_BITS_DEF   = 8;
  localparam int NUM_CHANNELS_DEF = 3;
  localparam int CFG_IDX_W        = 2;
  localparam int STEP_W           = $clog2(LEVEL_W);

  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_LEVEL = 2'd1;

  localparam logic FUNC_MEASURE = 1'b0;
  localparam logic FUNC_MAP     = 1'b1;

  typedef struct packed {
    logic              func;
    logic              first;
    logic [CHAN_W-1:0] chan_a;
    logic [CHAN_W-1:0] chan_b;
    logic [CHAN_W-1:0] chan_c;
  } pix_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] out_a;
    logic [LEVEL_W-1:0] out_b;
    logic [LEVEL_W-1:0] out_c;
  } res_t;

  // Sequencer to lanes
  typedef struct packed {
    logic meas;      // fold pixel into running min/max
    logic first;     // restart min/max with this pixel
    logic map_load;  // capture operands of a map word
    logic mul;       // form (v-lo)*(top-min)
    logic step;      // one restoring divide step
  } lane_ctl_t;

endpackage

`default_nettype wire

// ===== sv/mmcs_lane.sv =====
// One channel lane: running min/max, multiplier and bit-serial divider.
// Depends on mmcs_pkg.
`default_nettype none

module mmcs_lane #(
  parameter int VAL_W = mmcs_pkg::PIXEL_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire mmcs_pkg::lane_ctl_t          ctl,
  input  wire [mmcs_pkg::CHAN_W-1:0]        chan,
  input  wire [mmcs_pkg::LEVEL_W-1:0]       min_level,
  input  wire [mmcs_pkg::LEVEL_W-1:0]       top_level,
  output logic [mmcs_pkg::LEVEL_W-1:0]      result
);

  localparam int LW     = mmcs_pkg::LEVEL_W;
  localparam int PROD_W = VAL_W + LW;

  logic [VAL_W-1:0]  v;
  logic [VAL_W-1:0]  lo;
  logic [VAL_W-1:0]  hi;

  logic              special;
  logic              sat_top;
  logic [VAL_W-1:0]  dv;
  logic [VAL_W-1:0]  dd;
  logic [LW-1:0]     dl;
  logic [LW-1:0]     ml;
  logic [LW-1:0]     tl;

  logic [VAL_W-1:0]  rem;
  logic [LW-1:0]     low;
  logic [LW-1:0]     quo;

  logic [PROD_W-1:0] prod;
  logic [VAL_W:0]    trial;
  logic              fits;

  assign v     = chan[VAL_W-1:0];
  assign prod  = PROD_W'(dv) * PROD_W'(dl);
  assign trial = {rem, low[LW-1]};
  assign fits  = trial >= {1'b0, dd};

  always_ff @(posedge clk) begin
    if (rst) begin
      lo <= '1;
      hi <= '0;
    end else if (ctl.meas) begin
      if (ctl.first) begin
        lo <= v;
        hi <= v;
      end else begin
        if (v < lo) lo <= v;
        if (v > hi) hi <= v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.map_load) begin
      special <= (top_level < min_level) || (hi <= lo) || (v <= lo);
      sat_top <= v >= hi;
      dv      <= v - lo;
      dd      <= hi - lo;
      dl      <= top_level - min_level;
      ml      <= min_level;
      tl      <= top_level;
    end
    // quotient fits in LW bits, so the upper product bits start below dd
    if (ctl.mul) begin
      rem <= prod[PROD_W-1 -: VAL_W];
      low <= prod[LW-1:0];
      quo <= '0;
    end else if (ctl.step) begin
      rem <= fits ? VAL_W'(trial - {1'b0, dd}) : trial[VAL_W-1:0];
      low <= {low[LW-2:0], 1'b0};
      quo <= {quo[LW-2:0], fits};
    end
  end

  always_comb begin
    if (special)      result = ml;
    else if (sat_top) result = tl;
    else              result = quo + ml;
  end

endmodule

`default_nettype wire

// ===== sv/mmcs_merge.sv =====
// Merging stage: gathers lane results into the output word register.
// Depends on mmcs_pkg.
`default_nettype none

module mmcs_merge #(
  parameter int LANES = mmcs_pkg::NUM_CHANNELS_DEF
) (
  input  wire                                       clk,
  input  wire                                       rst,
  input  wire                                       load,
  input  wire [LANES-1:0][mmcs_pkg::LEVEL_W-1:0]    lane_res,
  output logic                                      free,
  output logic                                      res_valid,
  input  wire                                       res_ready,
  output mmcs_pkg::res_t                            res
);

  localparam int LW = mmcs_pkg::LEVEL_W;

  logic [mmcs_pkg::MAX_LANES-1:0][LW-1:0] full;

  // lanes beyond the channel count read as zero
  always_comb begin
    full = '0;
    for (int i = 0; i < LANES; i++) begin
      full[i] = lane_res[i];
    end
  end

  assign free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.out_a <= full[0];
      res.out_b <= full[1];
      res.out_c <= full[2];
    end
  end

endmodule

`default_nettype wire

// ===== sv/minmax_contrast_stretch.sv =====
// Top level of the per-channel min/max contrast stretch: config registers,
// sequencer, channel lanes and merging stage. Depends on mmcs_pkg,
// mmcs_lane and mmcs_merge.
//
//  channel | signals                         | role
//  --------+---------------------------------+------------------------------
//  pix     | pix_valid, pix_ready, pix       | pixel word in (measure/map)
//  res     | res_valid, res_ready, res       | stretched pixel word out
//  cfg     | cfg_valid, cfg_ready, cfg_index,| min_level / top_level write
//          | cfg_data                        |
//
// A measure word leaves the block idle. A map word runs through capture, one
// multiply, LEVEL_W (8) restoring divide steps in each lane, then the load
// of the output register.
// A map word waits in its last state while the output register is full and
// not being taken. A new pixel word is taken while a result still waits.
// Reset is synchronous; min/max restart to all ones / zero, levels to 0/255.
`default_nettype none

module minmax_contrast_stretch #(
  parameter int PIXEL_BITS   = mmcs_pkg::PIXEL_BITS_DEF,
  parameter int NUM_CHANNELS = mmcs_pkg::NUM_CHANNELS_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                pix_valid,
  output logic                               pix_ready,
  input  wire mmcs_pkg::pix_t                pix,
  output logic                               res_valid,
  input  wire                                res_ready,
  output mmcs_pkg::res_t                     res,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [mmcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [mmcs_pkg::LEVEL_W-1:0]        cfg_data
);

  localparam int LW    = mmcs_pkg::LEVEL_W;
  localparam int VAL_W = (PIXEL_BITS < mmcs_pkg::CHAN_W) ? PIXEL_BITS : mmcs_pkg::CHAN_W;
  localparam int LANES = (NUM_CHANNELS < mmcs_pkg::MAX_LANES) ? NUM_CHANNELS
                                                              : mmcs_pkg::MAX_LANES;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                         state;
  state_t                         state_next;
  logic [mmcs_pkg::STEP_W-1:0]    step_cnt;
  logic [LW-1:0]                  min_level;
  logic [LW-1:0]                  top_level;
  logic                           pix_acc;
  logic                           free;
  logic                           load;
  mmcs_pkg::lane_ctl_t            ctl;
  logic [mmcs_pkg::MAX_LANES-1:0][mmcs_pkg::CHAN_W-1:0] chan_vals;
  logic [LANES-1:0][LW-1:0]       lane_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_level <= '0;
      top_level <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mmcs_pkg::REG_MIN_LEVEL: min_level <= cfg_data;
        mmcs_pkg::REG_TOP_LEVEL: top_level <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pix_ready = (state == S_IDLE);
  assign pix_acc   = pix_valid && pix_ready;
  assign load      = (state == S_DONE) && free;

  always_comb begin
    ctl.meas     = pix_acc && (pix.func == mmcs_pkg::FUNC_MEASURE);
    ctl.first    = pix.first;
    ctl.map_load = pix_acc && (pix.func == mmcs_pkg::FUNC_MAP);
    ctl.mul      = (state == S_MUL);
    ctl.step     = (state == S_DIV);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (ctl.map_load) state_next = S_MUL;
      S_MUL:  state_next = S_DIV;
      S_DIV:  if (step_cnt == mmcs_pkg::STEP_W'(LW - 1)) state_next = S_DONE;
      S_DONE: if (free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_DIV) step_cnt <= step_cnt + 1'b1;
      else                step_cnt <= '0;
    end
  end

  assign chan_vals[0] = pix.chan_a;
  assign chan_vals[1] = pix.chan_b;
  assign chan_vals[2] = pix.chan_c;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    mmcs_lane #(
      .VAL_W (VAL_W)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .chan      (chan_vals[i]),
      .min_level (min_level),
      .top_level (top_level),
      .result    (lane_res[i])
    );
  end

  mmcs_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .lane_res  (lane_res),
    .free      (free),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

`default_nettype wire

// ===== sv/mmcs_checker.sv =====
// Port-level checks for minmax_contrast_stretch, bound to the top level.
// Depends on mmcs_pkg.
`default_nettype none

module mmcs_checker (
  input wire                            clk,
  input wire                            rst,
  input wire                            pix_valid,
  input wire                            pix_ready,
  input wire mmcs_pkg::pix_t            pix,
  input wire                            res_valid,
  input wire                            res_ready,
  input wire mmcs_pkg::res_t            res,
  input wire                            cfg_valid,
  input wire                            cfg_ready
);

  // result word holds while stalled
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result word changed while stalled");

  // a measure word never raises a result
  a_meas_silent: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_ready && (pix.func == mmcs_pkg::FUNC_MEASURE)
      |=> !$rose(res_valid))
    else $error("measure word produced a result");

  // a map word keeps the block busy while it divides
  a_map_busy: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_ready && (pix.func == mmcs_pkg::FUNC_MAP) |=> !pix_ready)
    else $error("pixel taken during a map word");

  // config writes are never held off
  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind minmax_contrast_stretch mmcs_checker u_mmcs_checker (.*);

`default_nettype wire
